// ----- rtl/core/msmg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msmg_pkg: shared types and constants
// Mode codes, status codes, motion kinds, controller states and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package msmg_pkg;

  localparam int MaxJoints = 8;
  localparam int InJoints = 6;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_POSE  = 2'd1,
    MODE_RAMP  = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_MOVING   = 3'd1,
    ST_FINISHED = 3'd2,
    ST_ABORTED  = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_IDLE = 2'd0,
    KIND_POSE = 2'd1,
    KIND_RAMP = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_JOINT,
    S_DIV,
    S_WRITE,
    S_DONE,
    S_OUT
  } fsm_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;    // latch the input transaction
    logic decode;     // evaluate the mode, finish simple cases
    logic joint_init; // start work on the current joint
    logic div_step;   // one restoring-divide step
    logic joint_wr;   // commit the current joint
    logic finish;     // settle status and kind after all joints
    logic out_load;   // load the output register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_loop;  // the transaction needs the per-joint loop
    logic need_div;   // the current joint needs a divide
    logic div_done;
    logic last_joint;
  } sts_t;

  localparam logic [15:0] LimLo [MaxJoints] = '{
    16'd425, 16'd720, 16'd315, 16'd320, 16'd790, 16'd330, 16'd0, 16'd0};
  localparam logic [15:0] LimHi [MaxJoints] = '{
    16'd2110, 16'd2720, 16'd2695, 16'd2720, 16'd1595, 16'd2640,
    16'd65535, 16'd65535};
  localparam logic [15:0] HomePos = 16'd1500;

endpackage

// ----- rtl/core/msmg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msmg_ctrl: sequencing controller
// Steps the datapath through decode, per-joint work and the output load.
// ----------------------------------------------------------------------------
module msmg_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_full,
  input  msmg_pkg::sts_t  sts,
  output msmg_pkg::cmd_t  cmd
);
  import msmg_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = sts.need_loop ? S_JOINT : S_OUT;
      S_JOINT:  state_nxt = sts.need_div ? S_DIV : S_WRITE;
      S_DIV:    if (sts.div_done) state_nxt = S_WRITE;
      S_WRITE:  state_nxt = sts.last_joint ? S_DONE : S_JOINT;
      S_DONE:   state_nxt = S_OUT;
      S_OUT:    if (!out_full) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      S_DECODE: cmd.decode = 1'b1;
      S_JOINT:  cmd.joint_init = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_WRITE:  cmd.joint_wr = 1'b1;
      S_DONE:   cmd.finish = 1'b1;
      S_OUT:    cmd.out_load = !out_full;
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/msmg_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msmg_dp: motion datapath
// Joint registers, clamp, distance max, shared restoring divider, ramp logic.
// ----------------------------------------------------------------------------
module msmg_dp #(
  parameter int NUM_JOINTS = 6,
  parameter int PULSE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_step_div,
  input  msmg_pkg::cmd_t        cmd,
  output msmg_pkg::sts_t        sts,
  input  logic [1:0]            in_mode,
  input  logic [2:0]            in_joint_select,
  input  logic [9:0]            in_step_increment,
  input  logic [11:0]           in_single_target,
  input  logic [11:0]           in_targets [msmg_pkg::InJoints],
  output logic [11:0]           pulse [msmg_pkg::InJoints],
  output logic                  busy,
  output logic [2:0]            status
);
  import msmg_pkg::*;

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int PW = PULSE_BITS;
  localparam int QW = PW + 12;   // dividend bits for |d| * s (12-bit s)
  localparam int CW = $clog2(QW + 1);
  localparam logic [PW-1:0] PMax = {PW{1'b1}};

  logic [PW-1:0] pos_r    [NUM_JOINTS];
  logic [PW-1:0] mstart_r [NUM_JOINTS];
  logic [PW-1:0] mtgt_r   [NUM_JOINTS];
  logic [11:0]   sidx_r, stot_r;
  kind_t         kind_r;
  logic [JW-1:0] rjoint_r;
  logic          rup_r;
  logic [9:0]    rinc_r;
  logic [7:0]    pstep_r;

  logic [1:0]    mode_r;
  logic [2:0]    sel_r;
  logic [9:0]    inc_r;
  logic [11:0]   single_r;
  logic [11:0]   tgt_r [InJoints];
  status_t       st_r;
  logic [JW-1:0] j_r;
  logic [PW-1:0] maxd_r;

  // divider
  logic [QW-1:0] dvd_r;
  logic [15:0]   dvs_r;
  logic [QW-1:0] quo_r;
  logic [16:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic          divbusy_r;

  function automatic logic [PW-1:0] clampj(input int j, input logic [15:0] v);
    logic [15:0] hi, lo, vv;
    hi = (LimHi[j] > 16'(PMax)) ? 16'(PMax) : LimHi[j];
    lo = (LimLo[j] > hi) ? hi : LimLo[j];
    vv = v;
    if (vv < lo) vv = lo;
    if (vv > hi) vv = hi;
    return PW'(vv);
  endfunction

  function automatic logic [PW-1:0] rclamp_f(input logic [JW-1:0] j,
                                             input logic [15:0] v);
    logic [PW-1:0] r;
    r = PW'(v);
    for (int k = 0; k < NUM_JOINTS; k++) if (j == JW'(k)) r = clampj(k, v);
    return r;
  endfunction

  // per-joint pose target
  logic [PW-1:0] ptgt [NUM_JOINTS];
  always_comb begin
    for (int i = 0; i < NUM_JOINTS; i++) begin
      if (i < InJoints) ptgt[i] = clampj(i, 16'(tgt_r[(i < InJoints) ? i : 0]));
      else              ptgt[i] = clampj(i, 16'(pos_r[i]));
    end
  end

  logic [PW-1:0] cur_pos, cur_tgt, cur_st, jdist;
  logic [JW-1:0] rsel;
  logic [PW-1:0] rclamp;
  logic          sel_ok;
  logic [PW:0]   rup_sum;
  logic [PW-1:0] rnew;
  logic [PW-1:0] ddiff;
  logic          dneg;
  logic [16:0]   rem_sh;
  logic [PW:0]   pose_sum;
  logic [11:0]   steps_q;

  assign cur_pos = pos_r[j_r];
  assign cur_tgt = ptgt[j_r];
  assign cur_st  = mstart_r[j_r];
  assign jdist   = (cur_tgt > cur_pos) ? cur_tgt - cur_pos : cur_pos - cur_tgt;
  assign rsel    = sel_r[JW-1:0];
  assign sel_ok  = 32'(sel_r) < NUM_JOINTS;
  assign rclamp  = rclamp_f(rsel, 16'(single_r));
  assign dneg    = mtgt_r[j_r] < mstart_r[j_r];
  assign ddiff   = dneg ? mstart_r[j_r] - mtgt_r[j_r] : mtgt_r[j_r] - mstart_r[j_r];
  assign rem_sh  = {rem_r[15:0], dvd_r[QW-1]};

  // ramp step on the ramp joint
  always_comb begin
    logic [PW-1:0] c, t;
    c = pos_r[rjoint_r];
    t = mtgt_r[rjoint_r];
    rup_sum = {1'b0, c} + (PW+1)'(rinc_r);
    if (rup_r) begin
      rnew = (rup_sum > {1'b0, t}) ? t : rup_sum[PW-1:0];
    end else begin
      rnew = ((PW+1)'(c) >= (PW+1)'(rinc_r)) ? PW'((PW+1)'(c) - (PW+1)'(rinc_r)) : '0;
      if (rnew < t) rnew = t;
    end
  end

  // pose position: start +/- |d|*s/steps
  assign pose_sum = neg_r ? (PW+1)'(cur_st) - (PW+1)'(quo_r)
                          : (PW+1)'(cur_st) + (PW+1)'(quo_r);
  // steps = quotient truncated to 12 bits; below 1 maps to 1
  assign steps_q  = (quo_r == '0) ? 12'd1 : quo_r[11:0];

  assign sts.need_loop  = (mode_r == MODE_TICK && kind_r == KIND_POSE) ||
                          (mode_r == MODE_POSE && kind_r == KIND_IDLE);
  assign sts.need_div   = 1'b1;
  assign sts.div_done   = !divbusy_r;
  assign sts.last_joint = (32'(j_r) == NUM_JOINTS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_JOINTS; i++) pos_r[i] <= PW'(HomePos) & PMax;
      sidx_r <= '0; stot_r <= 12'd1; kind_r <= KIND_IDLE;
      rjoint_r <= '0; rup_r <= 1'b0; rinc_r <= 10'd1; pstep_r <= 8'd5;
      divbusy_r <= 1'b0;
    end else begin
      if (cfg_we) pstep_r <= cfg_step_div;
      if (cmd.capture) begin
        mode_r <= in_mode; sel_r <= in_joint_select; inc_r <= in_step_increment;
        single_r <= in_single_target; tgt_r <= in_targets;
      end
      if (cmd.decode) begin
        j_r <= '0;
        maxd_r <= '0;
        st_r <= ST_IDLE;
        case (mode_r)
          MODE_TICK: begin
            if (kind_r == KIND_POSE) begin
              sidx_r <= sidx_r + 12'd1;
            end else if (kind_r == KIND_RAMP) begin
              pos_r[rjoint_r] <= rnew;
              if (rnew == mtgt_r[rjoint_r]) begin
                kind_r <= KIND_IDLE; st_r <= ST_FINISHED;
              end else st_r <= ST_MOVING;
            end
          end
          MODE_STOP: if (kind_r != KIND_IDLE) begin
            kind_r <= KIND_IDLE; st_r <= ST_ABORTED;
          end
          default: begin
            if (kind_r != KIND_IDLE) st_r <= ST_REJECTED;
            else if (mode_r == MODE_POSE) st_r <= ST_IDLE;
            else if (sel_ok) begin
              rjoint_r <= rsel;
              rinc_r <= (inc_r == '0) ? 10'd1 : inc_r;
              mstart_r[rsel] <= pos_r[rsel];
              mtgt_r[rsel] <= rclamp;
              if (rclamp == pos_r[rsel]) st_r <= ST_FINISHED;
              else begin
                rup_r <= rclamp > pos_r[rsel];
                kind_r <= KIND_RAMP; st_r <= ST_MOVING;
              end
            end
          end
        endcase
      end
      if (cmd.joint_init) begin
        divbusy_r <= 1'b1;
        cnt_r <= CW'(QW);
        rem_r <= '0;
        quo_r <= '0;
        if (mode_r == MODE_POSE) begin
          // pose start: record joint, divide the running max distance by the divisor
          mstart_r[j_r] <= cur_pos;
          mtgt_r[j_r] <= cur_tgt;
          if (jdist > maxd_r) maxd_r <= jdist;
          neg_r <= 1'b0;
          dvd_r <= QW'((jdist > maxd_r) ? jdist : maxd_r);
          dvs_r <= (pstep_r == '0) ? 16'd1 : 16'(pstep_r);
        end else begin
          neg_r <= dneg;
          dvd_r <= QW'(ddiff) * QW'(sidx_r);
          dvs_r <= 16'(stot_r);
        end
      end
      if (cmd.div_step && divbusy_r) begin
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= rem_sh - {1'b0, dvs_r};
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
        dvd_r <= {dvd_r[QW-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) divbusy_r <= 1'b0;
      end
      if (cmd.joint_wr) begin
        if (mode_r != MODE_POSE) pos_r[j_r] <= pose_sum[PW-1:0];
        else if (32'(j_r) == NUM_JOINTS - 1) begin
          stot_r <= (steps_q == 12'd0) ? 12'hFFF : steps_q;
        end
        if (32'(j_r) != NUM_JOINTS - 1) j_r <= j_r + JW'(1);
      end
      if (cmd.finish) begin
        if (mode_r == MODE_POSE) begin
          sidx_r <= '0; kind_r <= KIND_POSE; st_r <= ST_MOVING;
        end else if (sidx_r >= stot_r) begin
          kind_r <= KIND_IDLE; st_r <= ST_FINISHED;
        end else st_r <= ST_MOVING;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < InJoints; i++)
      pulse[i] = (i < NUM_JOINTS) ? 12'(pos_r[i < NUM_JOINTS ? i : 0]) : 12'd0;
    busy = kind_r != KIND_IDLE;
    status = st_r;
  end

endmodule

// ----- rtl/core/multi_joint_servo_motion_generator.sv -----
`timescale 1ns / 1ps
// Stops, ramp ticks, ramp and rejected starts go from decode straight to the output load;
// a pose tick or pose start also steps through every joint, each one visiting the shared
// bit-serial divider before its joint is written.
// Throughput: one transaction at a time; the next is taken in the cycle after the result
// loads, later while the previous result waits on out_stall.
// Reset: synchronous active-low rst_n; joints return to 1500, motion idle, divisor 5.
// ----------------------------------------------------------------------------
// multi_joint_servo_motion_generator: six-joint servo interpolator
// Pose moves by linear interpolation and single-joint ramps, one result per
// input transaction.
// ----------------------------------------------------------------------------
module multi_joint_servo_motion_generator #(
  parameter int NUM_JOINTS = 6,
  parameter int PULSE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_step_div,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_joint_select,
  input  logic [9:0]  in_step_increment,
  input  logic [11:0] in_single_target,
  input  logic [11:0] in_target_0,
  input  logic [11:0] in_target_1,
  input  logic [11:0] in_target_2,
  input  logic [11:0] in_target_3,
  input  logic [11:0] in_target_4,
  input  logic [11:0] in_target_5,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pulse_0,
  output logic [11:0] out_pulse_1,
  output logic [11:0] out_pulse_2,
  output logic [11:0] out_pulse_3,
  output logic [11:0] out_pulse_4,
  output logic [11:0] out_pulse_5,
  output logic        out_busy_res,
  output logic [2:0]  out_status
);
  import msmg_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [11:0] tg [InJoints];
  logic [11:0] pl [InJoints];
  logic        busy;
  logic [2:0]  status;
  logic        out_valid_r;
  logic [11:0] opl_r [InJoints];
  logic        obusy_r;
  logic [2:0]  ost_r;

  assign tg = '{in_target_0, in_target_1, in_target_2, in_target_3, in_target_4,
                in_target_5};

  msmg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .out_full(out_valid_r && out_stall), .sts, .cmd
  );

  msmg_dp #(.NUM_JOINTS(NUM_JOINTS), .PULSE_BITS(PULSE_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_step_div, .cmd, .sts,
    .in_mode, .in_joint_select, .in_step_increment, .in_single_target,
    .in_targets(tg), .pulse(pl), .busy, .status
  );

  // Output register: load on the controller's request, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      opl_r <= pl; obusy_r <= busy; ost_r <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pulse_0 = opl_r[0];
  assign out_pulse_1 = opl_r[1];
  assign out_pulse_2 = opl_r[2];
  assign out_pulse_3 = opl_r[3];
  assign out_pulse_4 = opl_r[4];
  assign out_pulse_5 = opl_r[5];
  assign out_busy_res = obusy_r;
  assign out_status = ost_r;

endmodule

// ----- rtl/core/msmg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msmg_checker: port-level checks
// Handshake and result consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
module msmg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_busy_res,
  input logic [2:0] out_status
);
  import msmg_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_REJECTED)
    else $error("status out of range");

  a_moving_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MOVING || out_status == ST_REJECTED)
      |-> out_busy_res)
    else $error("moving without busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FINISHED || out_status == ST_ABORTED)
      |-> !out_busy_res)
    else $error("finished while busy");

endmodule

bind multi_joint_servo_motion_generator msmg_checker u_msmg_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_busy_res, .out_status
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: servo motion generator testbench
// Drives pose, ramp, tick and stop transactions under random valid/stall gaps,
// predicts every result with a local joint model and compares it with the port values.
// ----------------------------------------------------------------------------
module tb_top;
  import msmg_pkg::*;

  localparam int NJ = 6;
  localparam int PMAX = 4095;
  localparam int DRAIN = 400;

  typedef struct {
    logic [1:0]  mode;
    logic [2:0]  sel;
    logic [9:0]  inc;
    logic [11:0] single;
    logic [11:0] tgt [NJ];
  } cmd_item_t;

  typedef struct packed {
    logic [11:0] p5, p4, p3, p2, p1, p0;
    logic        busy;
    logic [2:0]  status;
  } servo_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_step_div = 8'd5;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [2:0] in_joint_select = '0;
  logic [9:0] in_step_increment = '0;
  logic [11:0] in_single_target = '0;
  logic [11:0] in_target_0 = '0, in_target_1 = '0, in_target_2 = '0;
  logic [11:0] in_target_3 = '0, in_target_4 = '0, in_target_5 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] out_pulse_0, out_pulse_1, out_pulse_2, out_pulse_3, out_pulse_4, out_pulse_5;
  logic out_busy_res;
  logic [2:0] out_status;

  always #2 clk = ~clk;

  multi_joint_servo_motion_generator dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_step_div(cfg_step_div),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_joint_select(in_joint_select), .in_step_increment(in_step_increment),
    .in_single_target(in_single_target), .in_target_0(in_target_0),
    .in_target_1(in_target_1), .in_target_2(in_target_2), .in_target_3(in_target_3),
    .in_target_4(in_target_4), .in_target_5(in_target_5), .out_valid(out_valid),
    .out_stall(out_stall), .out_pulse_0(out_pulse_0), .out_pulse_1(out_pulse_1),
    .out_pulse_2(out_pulse_2), .out_pulse_3(out_pulse_3), .out_pulse_4(out_pulse_4),
    .out_pulse_5(out_pulse_5), .out_busy_res(out_busy_res), .out_status(out_status)
  );

  // Local copy of the motion state
  int unsigned pose_div;
  int unsigned joint_pos [NJ];
  int unsigned seg_start [NJ];
  int unsigned seg_target [NJ];
  int unsigned step_idx, step_cnt, ramp_jnt, ramp_inc;
  bit ramp_rising;
  kind_t motion;

  servo_res_t expected_pulses [$];
  int mismatches = 0;
  bit hold_off = 1'b0;
  int stall_cycles = 0;

  function automatic int unsigned clamp_target(int j, int unsigned v);
    int unsigned hi;
    int unsigned lo;
    hi = (LimHi[j] > PMAX) ? PMAX : LimHi[j];
    lo = (LimLo[j] > hi) ? hi : LimLo[j];
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the model by one transaction and return the result it causes
  function automatic servo_res_t predict_motion(cmd_item_t c);
    servo_res_t r;
    status_t st;
    int unsigned maxd, d, t, cur, steps;
    longint dl, v;
    st = ST_IDLE;
    if (c.mode == MODE_TICK) begin
      if (motion == KIND_POSE) begin
        step_idx = (step_idx + 1) & 12'hFFF;
        for (int i = 0; i < NJ; i++) begin
          dl = longint'(seg_target[i]) - longint'(seg_start[i]);
          v = longint'(seg_start[i]) + dl * longint'(step_idx) / longint'(step_cnt);
          joint_pos[i] = int'(v) & PMAX;
        end
        if (step_idx >= step_cnt) begin
          motion = KIND_IDLE;
          st = ST_FINISHED;
        end else st = ST_MOVING;
      end else if (motion == KIND_RAMP) begin
        cur = joint_pos[ramp_jnt];
        t = seg_target[ramp_jnt];
        if (ramp_rising) begin
          cur += ramp_inc;
          if (cur > t) cur = t;
        end else begin
          cur = (cur >= ramp_inc) ? cur - ramp_inc : 0;
          if (cur < t) cur = t;
        end
        joint_pos[ramp_jnt] = cur & PMAX;
        if (cur == t) begin
          motion = KIND_IDLE;
          st = ST_FINISHED;
        end else st = ST_MOVING;
      end
    end else if (c.mode == MODE_STOP) begin
      if (motion != KIND_IDLE) begin
        motion = KIND_IDLE;
        st = ST_ABORTED;
      end
    end else if (motion != KIND_IDLE) begin
      st = ST_REJECTED;
    end else if (c.mode == MODE_POSE) begin
      maxd = 0;
      for (int i = 0; i < NJ; i++) begin
        t = clamp_target(i, c.tgt[i]);
        seg_start[i] = joint_pos[i];
        seg_target[i] = t;
        d = (t > joint_pos[i]) ? t - joint_pos[i] : joint_pos[i] - t;
        if (d > maxd) maxd = d;
      end
      steps = maxd / ((pose_div == 0) ? 1 : pose_div);
      if (steps < 1) steps = 1;
      step_cnt = steps & 12'hFFF;
      if (step_cnt == 0) step_cnt = 12'hFFF;
      step_idx = 0;
      motion = KIND_POSE;
      st = ST_MOVING;
    end else if (c.sel < NJ) begin
      t = clamp_target(c.sel, c.single);
      ramp_jnt = c.sel;
      ramp_inc = (c.inc == 0) ? 1 : c.inc;
      seg_start[c.sel] = joint_pos[c.sel];
      seg_target[c.sel] = t;
      if (t == joint_pos[c.sel]) st = ST_FINISHED;
      else begin
        ramp_rising = t > joint_pos[c.sel];
        motion = KIND_RAMP;
        st = ST_MOVING;
      end
    end
    r.p0 = 12'(joint_pos[0]); r.p1 = 12'(joint_pos[1]); r.p2 = 12'(joint_pos[2]);
    r.p3 = 12'(joint_pos[3]); r.p4 = 12'(joint_pos[4]); r.p5 = 12'(joint_pos[5]);
    r.busy = (motion != KIND_IDLE);
    r.status = st;
    return r;
  endfunction

  // Offer one transaction after a random gap, hold it until accepted;
  // valid stays up when the next transaction follows with no gap
  task automatic send_cmd(cmd_item_t c);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_pulses.push_back(predict_motion(c));
    in_valid <= 1'b1;
    in_mode <= c.mode;
    in_joint_select <= c.sel;
    in_step_increment <= c.inc;
    in_single_target <= c.single;
    in_target_0 <= c.tgt[0]; in_target_1 <= c.tgt[1]; in_target_2 <= c.tgt[2];
    in_target_3 <= c.tgt[3]; in_target_4 <= c.tgt[4]; in_target_5 <= c.tgt[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic cmd_item_t rand_cmd(mode_t m);
    cmd_item_t c;
    c.mode = m;
    c.sel = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5));
    c.inc = 10'(($urandom_range(0, 1)) ? $urandom_range(0, 1023) : $urandom_range(1, 60));
    c.single = 12'($urandom_range(0, 4095));
    for (int i = 0; i < NJ; i++)
      c.tgt[i] = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(300, 2800));
    return c;
  endfunction

  // Drop valid, wait for every expected result, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_step_div(logic [7:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_step_div <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pose_div = v;
  endtask

  task automatic test_directed();
    cmd_item_t c;
    c = rand_cmd(MODE_TICK);
    send_cmd(c);                          // tick while idle
    c.mode = MODE_STOP; send_cmd(c);      // stop while idle
    c = rand_cmd(MODE_POSE);
    foreach (c.tgt[i]) c.tgt[i] = 12'hFFF; // clamp to upper limits
    send_cmd(c);
    c.mode = MODE_RAMP; send_cmd(c);      // rejected while busy
    c.mode = MODE_POSE; send_cmd(c);
    repeat (3) begin c.mode = MODE_TICK; send_cmd(c); end
    c.mode = MODE_STOP; send_cmd(c);      // abort
    c = rand_cmd(MODE_POSE);
    foreach (c.tgt[i]) c.tgt[i] = 12'h000; // clamp to lower limits
    send_cmd(c);
    repeat (5) begin c.mode = MODE_TICK; send_cmd(c); end
    c = rand_cmd(MODE_RAMP);
    c.sel = 3'd7; send_cmd(c);            // joint out of range
    c.sel = 3'd0; c.inc = 10'd0; c.single = 12'hFFF; send_cmd(c); // zero increment
    repeat (3) begin c.mode = MODE_TICK; send_cmd(c); end
    c.mode = MODE_STOP; send_cmd(c);
    c = rand_cmd(MODE_RAMP);
    c.sel = 3'd5; c.inc = 10'h3FF; c.single = 12'd0; send_cmd(c);
    c.mode = MODE_TICK; send_cmd(c); send_cmd(c);
    c = rand_cmd(MODE_RAMP);
    c.sel = 3'd1; c.single = 12'(joint_pos[1]); send_cmd(c); // already at target
  endtask

  // Mostly start-then-tick sequences so moves run to completion
  task automatic test_random(int n);
    cmd_item_t c;
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      c = rand_cmd(($urandom_range(0, 1)) ? MODE_POSE : MODE_RAMP);
      send_cmd(c); sent++;
      len = $urandom_range(1, 30);
      for (int k = 0; k < len && sent < n; k++) begin
        case ($urandom_range(0, 19))
          0:       c = rand_cmd(MODE_STOP);
          1:       c = rand_cmd(MODE_POSE);
          2:       c = rand_cmd(MODE_RAMP);
          default: c = rand_cmd(MODE_TICK);
        endcase
        send_cmd(c); sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(40);
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  // Receiver stall: random gaps, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cycles <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    servo_res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_pulse_5, out_pulse_4, out_pulse_3, out_pulse_2, out_pulse_1, out_pulse_0,
             out_busy_res, out_status};
      if (expected_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_pulses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected p=%0d %0d %0d %0d %0d %0d b=%0d s=%0d",
              want.p0, want.p1, want.p2, want.p3, want.p4, want.p5, want.busy, want.status);
            $display("          got      p=%0d %0d %0d %0d %0d %0d b=%0d s=%0d",
              got.p0, got.p1, got.p2, got.p3, got.p4, got.p5, got.busy, got.status);
          end
        end
      end
    end
  end

  initial begin
    pose_div = 5;
    foreach (joint_pos[i]) begin
      joint_pos[i] = HomePos; seg_start[i] = 0; seg_target[i] = 0;
    end
    step_idx = 0; step_cnt = 1; ramp_jnt = 0; ramp_inc = 1; ramp_rising = 0;
    motion = KIND_IDLE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (DRAIN) @(posedge clk);
    test_directed();
    write_step_div(8'd255);
    test_random(300);
    write_step_div(8'd1);
    test_random(200);
    write_step_div(8'd0);
    test_random(200);
    test_backpressure();
    write_step_div(8'd40);
    test_random(500);
    write_step_div(8'd5);
    test_random(560);
    drain_results();
    if (mismatches == 0) $display("multi_joint_servo_motion_generator test passed");
    else $display("multi_joint_servo_motion_generator test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("multi_joint_servo_motion_generator test failed");
    $finish;
  end

endmodule
